// File: rtl/core/camera_view_clamp_assert.svh
// assertion macros for the camera clamp checker
`ifndef CAMERA_VIEW_CLAMP_ASSERT_SVH
`define CAMERA_VIEW_CLAMP_ASSERT_SVH

`define CVC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cvc check failed");

`define CVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cvc check failed");

`endif

// File: rtl/core/cvc_pkg.sv
package cvc_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned VPW = 14;
  localparam int unsigned AW = 31;
  localparam int unsigned DIVW = 64;
  localparam int unsigned DIV_CNT_W = 7;

  localparam logic signed [QW-1:0] QMAX = 32'sh7fffffff;
  localparam logic signed [QW-1:0] QMIN = 32'sh80000000;
  localparam logic signed [QW-1:0] ZOOM_FLOOR = 32'sd66;
  localparam logic [QW-1:0] EFF_FLOOR = 32'd66191;

  localparam logic [VPW-1:0] RST_VW = 14'd1024;
  localparam logic [VPW-1:0] RST_VH = 14'd768;
  localparam logic [AW-1:0] RST_AW = 31'd67108864;
  localparam logic [AW-1:0] RST_AH = 31'd50331648;

  localparam logic [2:0] REG_VW = 3'd0;
  localparam logic [2:0] REG_VH = 3'd1;
  localparam logic [2:0] REG_CX = 3'd2;
  localparam logic [2:0] REG_CY = 3'd3;
  localparam logic [2:0] REG_AW = 3'd4;
  localparam logic [2:0] REG_AH = 3'd5;

  localparam logic [1:0] FN_SET_POS = 2'd0;
  localparam logic [1:0] FN_MOVE = 2'd1;
  localparam logic [1:0] FN_SET_ZOOM = 2'd2;
  localparam logic [1:0] FN_ADD_ZOOM = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RX_START,
    ST_RX_WAIT,
    ST_RY_START,
    ST_RY_WAIT,
    ST_FZ,
    ST_HW_START,
    ST_HW_WAIT,
    ST_HH_START,
    ST_HH_WAIT,
    ST_CLAMP,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    DSEL_RX,
    DSEL_RY,
    DSEL_HW,
    DSEL_HH
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     update;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_store;
    logic     calc_fz;
    logic     clamp;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [QW+1:0] v);
    if (v > QW'(QMAX)) return QMAX;
    else if (v < $signed({{2{1'b1}}, QMIN})) return QMIN;
    else return v[QW-1:0];
  endfunction

endpackage

// File: rtl/core/cvc_div.sv
module cvc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cvc_pkg::DIVW-1:0]    dividend,
  input  logic [cvc_pkg::QW-1:0]      divisor,
  output logic [cvc_pkg::DIVW-1:0]    quotient,
  output logic                        done
);

  logic [cvc_pkg::DIVW-1:0]      quo;
  logic [cvc_pkg::QW:0]          rem;
  logic [cvc_pkg::QW-1:0]        dvs;
  logic [cvc_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;
  logic [cvc_pkg::QW:0]          trial;
  logic [cvc_pkg::QW+1:0]        diff;

  assign trial = {rem[cvc_pkg::QW-1:0], quo[cvc_pkg::DIVW-1]};
  assign diff = {1'b0, trial} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == cvc_pkg::DIV_CNT_W'(cvc_pkg::DIVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[cvc_pkg::QW+1]) begin
        rem <= diff[cvc_pkg::QW:0];
        quo <= {quo[cvc_pkg::DIVW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[cvc_pkg::DIVW-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/core/cvc_ctrl.sv
module cvc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic            out_busy,
  input  cvc_pkg::stat_t  stat,
  output cvc_pkg::cmd_t   cmd
);

  cvc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= cvc_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cvc_pkg::ST_IDLE:     if (in_tvalid) state_next = cvc_pkg::ST_UPDATE;
      cvc_pkg::ST_UPDATE:   state_next = cvc_pkg::ST_RX_START;
      cvc_pkg::ST_RX_START: state_next = cvc_pkg::ST_RX_WAIT;
      cvc_pkg::ST_RX_WAIT:  if (stat.div_done) state_next = cvc_pkg::ST_RY_START;
      cvc_pkg::ST_RY_START: state_next = cvc_pkg::ST_RY_WAIT;
      cvc_pkg::ST_RY_WAIT:  if (stat.div_done) state_next = cvc_pkg::ST_FZ;
      cvc_pkg::ST_FZ:       state_next = cvc_pkg::ST_HW_START;
      cvc_pkg::ST_HW_START: state_next = cvc_pkg::ST_HW_WAIT;
      cvc_pkg::ST_HW_WAIT:  if (stat.div_done) state_next = cvc_pkg::ST_HH_START;
      cvc_pkg::ST_HH_START: state_next = cvc_pkg::ST_HH_WAIT;
      cvc_pkg::ST_HH_WAIT:  if (stat.div_done) state_next = cvc_pkg::ST_CLAMP;
      cvc_pkg::ST_CLAMP:    state_next = cvc_pkg::ST_OUT;
      cvc_pkg::ST_OUT:      if (!out_busy) state_next = cvc_pkg::ST_IDLE;
      default:              state_next = cvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = cvc_pkg::DSEL_RX;
    in_tready = 1'b0;
    unique case (state)
      cvc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load_in = in_tvalid;
      end
      cvc_pkg::ST_UPDATE: cmd.update = 1'b1;
      cvc_pkg::ST_RX_START: cmd.div_start = 1'b1;
      cvc_pkg::ST_RX_WAIT: cmd.div_store = stat.div_done;
      cvc_pkg::ST_RY_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = cvc_pkg::DSEL_RY;
      end
      cvc_pkg::ST_RY_WAIT: begin
        cmd.div_sel = cvc_pkg::DSEL_RY;
        cmd.div_store = stat.div_done;
      end
      cvc_pkg::ST_FZ: cmd.calc_fz = 1'b1;
      cvc_pkg::ST_HW_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = cvc_pkg::DSEL_HW;
      end
      cvc_pkg::ST_HW_WAIT: begin
        cmd.div_sel = cvc_pkg::DSEL_HW;
        cmd.div_store = stat.div_done;
      end
      cvc_pkg::ST_HH_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = cvc_pkg::DSEL_HH;
      end
      cvc_pkg::ST_HH_WAIT: begin
        cmd.div_sel = cvc_pkg::DSEL_HH;
        cmd.div_store = stat.div_done;
      end
      cvc_pkg::ST_CLAMP: cmd.clamp = 1'b1;
      cvc_pkg::ST_OUT: cmd.out_load = !out_busy;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/cvc_dp.sv
module cvc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  cvc_pkg::cmd_t                     cmd,
  output cvc_pkg::stat_t                    stat,
  input  logic [1:0]                        func,
  input  logic signed [cvc_pkg::QW-1:0]     operand_a,
  input  logic signed [cvc_pkg::QW-1:0]     operand_b,
  input  logic [cvc_pkg::VPW-1:0]           vw,
  input  logic [cvc_pkg::VPW-1:0]           vh,
  input  logic signed [cvc_pkg::QW-1:0]     cx,
  input  logic signed [cvc_pkg::QW-1:0]     cy,
  input  logic [cvc_pkg::AW-1:0]            aw,
  input  logic [cvc_pkg::AW-1:0]            ah,
  output logic signed [cvc_pkg::QW-1:0]     res_x,
  output logic signed [cvc_pkg::QW-1:0]     res_y,
  output logic [cvc_pkg::AW-1:0]            res_hw,
  output logic [cvc_pkg::AW-1:0]            res_hh,
  output logic [cvc_pkg::AW-1:0]            res_zoom
);

  localparam int unsigned QW = cvc_pkg::QW;

  logic [1:0]              fn;
  logic signed [QW-1:0]    op_a, op_b;
  logic signed [QW-1:0]    cam_x, cam_y, zoom;
  logic [QW-1:0]           rx, ry, fz, hw, hh;
  logic [cvc_pkg::DIVW-1:0] div_dividend, div_q;
  logic [QW-1:0]           div_divisor;
  logic                    div_zero;
  logic [QW-1:0]           q_sat;
  logic signed [QW+1:0]    sum_x, sum_y, sum_z, zoom_sel;
  logic [QW:0]             fz_sum;
  logic [QW-1:0]           r_min, fz_sat;

  always_comb begin
    div_dividend = '0;
    div_divisor = {1'b0, aw};
    unique case (cmd.div_sel)
      cvc_pkg::DSEL_RX: begin
        div_dividend = {18'd0, vw, 32'd0};
        div_divisor = {1'b0, aw};
      end
      cvc_pkg::DSEL_RY: begin
        div_dividend = {18'd0, vh, 32'd0};
        div_divisor = {1'b0, ah};
      end
      cvc_pkg::DSEL_HW: begin
        div_dividend = {19'd0, vw, 31'd0};
        div_divisor = fz;
      end
      cvc_pkg::DSEL_HH: begin
        div_dividend = {19'd0, vh, 31'd0};
        div_divisor = fz;
      end
      default: ;
    endcase
  end

  assign div_zero = (div_divisor == '0);
  assign q_sat = (div_zero || div_q[cvc_pkg::DIVW-1:QW-1] != '0) ?
                 QW'(cvc_pkg::QMAX) : div_q[QW-1:0];

  cvc_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(div_dividend), .divisor(div_divisor),
    .quotient(div_q), .done(stat.div_done)
  );

  assign sum_x = (QW+2)'(cam_x) + (QW+2)'(op_a);
  assign sum_y = (QW+2)'(cam_y) + (QW+2)'(op_b);
  assign sum_z = (QW+2)'(zoom) + (QW+2)'(op_a);
  assign zoom_sel = (fn == cvc_pkg::FN_SET_ZOOM) ? (QW+2)'(op_a) :
                    (QW+2)'(cvc_pkg::sat32(sum_z));

  assign r_min = (rx < ry) ? rx : ry;
  assign fz_sum = {1'b0, r_min} + {1'b0, zoom};
  assign fz_sat = (fz_sum > (QW+1)'(cvc_pkg::QMAX)) ? QW'(cvc_pkg::QMAX) : fz_sum[QW-1:0];

  function automatic logic signed [QW-1:0] clamp_axis(
    input logic signed [QW-1:0] p, input logic signed [QW-1:0] c,
    input logic [cvc_pkg::AW-1:0] sz, input logic [QW-1:0] half);
    logic signed [QW+2:0] ha, a, b, lo, hi, v;
    ha = (QW+3)'(sz >> 1);
    a = (QW+3)'(c) - ha + (QW+3)'(half);
    b = (QW+3)'(c) + ha - (QW+3)'(half);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    v = (QW+3)'(p);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return cvc_pkg::sat32(v[QW+1:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      zoom <= cvc_pkg::ZOOM_FLOOR;
    end else begin
      if (cmd.update) begin
        unique case (fn)
          cvc_pkg::FN_SET_POS: begin
            cam_x <= op_a;
            cam_y <= op_b;
          end
          cvc_pkg::FN_MOVE: begin
            cam_x <= cvc_pkg::sat32(sum_x);
            cam_y <= cvc_pkg::sat32(sum_y);
          end
          default: begin
            if (zoom_sel < (QW+2)'(cvc_pkg::ZOOM_FLOOR)) zoom <= cvc_pkg::ZOOM_FLOOR;
            else zoom <= zoom_sel[QW-1:0];
          end
        endcase
      end
      if (cmd.clamp) begin
        cam_x <= clamp_axis(cam_x, cx, aw, hw);
        cam_y <= clamp_axis(cam_y, cy, ah, hh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      fn <= func;
      op_a <= operand_a;
      op_b <= operand_b;
    end
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        cvc_pkg::DSEL_RX: rx <= q_sat;
        cvc_pkg::DSEL_RY: ry <= q_sat;
        cvc_pkg::DSEL_HW: hw <= div_q[QW-1:0];
        cvc_pkg::DSEL_HH: hh <= div_q[QW-1:0];
        default: ;
      endcase
    end
    if (cmd.calc_fz) fz <= (fz_sat < cvc_pkg::EFF_FLOOR) ? cvc_pkg::EFF_FLOOR : fz_sat;
  end

  assign res_x = cam_x;
  assign res_y = cam_y;
  assign res_hw = hw[cvc_pkg::AW-1:0];
  assign res_hh = hh[cvc_pkg::AW-1:0];
  assign res_zoom = zoom[cvc_pkg::AW-1:0];

endmodule

// File: rtl/core/camera_view_clamp.sv
// camera_view_clamp: one command in, one result out. each transaction makes
// four 64-step passes through the shared radix-2 divider
// (two viewport/area ratios, then two half extents). the output register lets
// the next command enter while a result still waits. the user must write the
// registers through the apb port only while idle; the block does not enforce it.
module camera_view_clamp (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // func[1:0], operand_a[33:2], operand_b[65:34]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // pos_x, pos_y, half_width, half_height, zoom_out
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [cvc_pkg::VPW-1:0]       vw, vh;
  logic signed [cvc_pkg::QW-1:0] cx, cy;
  logic [cvc_pkg::AW-1:0]        aw, ah;
  logic [2:0]                    ridx;
  cvc_pkg::cmd_t                 cmd;
  cvc_pkg::stat_t                stat;
  logic signed [cvc_pkg::QW-1:0] res_x, res_y;
  logic [cvc_pkg::AW-1:0]        res_hw, res_hh, res_zoom;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vw <= cvc_pkg::RST_VW;
      vh <= cvc_pkg::RST_VH;
      cx <= '0;
      cy <= '0;
      aw <= cvc_pkg::RST_AW;
      ah <= cvc_pkg::RST_AH;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        cvc_pkg::REG_VW: vw <= pwdata[cvc_pkg::VPW-1:0];
        cvc_pkg::REG_VH: vh <= pwdata[cvc_pkg::VPW-1:0];
        cvc_pkg::REG_CX: cx <= pwdata;
        cvc_pkg::REG_CY: cy <= pwdata;
        cvc_pkg::REG_AW: aw <= pwdata[cvc_pkg::AW-1:0];
        cvc_pkg::REG_AH: ah <= pwdata[cvc_pkg::AW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (ridx)
      cvc_pkg::REG_VW: prdata = {18'd0, vw};
      cvc_pkg::REG_VH: prdata = {18'd0, vh};
      cvc_pkg::REG_CX: prdata = cx;
      cvc_pkg::REG_CY: prdata = cy;
      cvc_pkg::REG_AW: prdata = {1'b0, aw};
      cvc_pkg::REG_AH: prdata = {1'b0, ah};
      default: prdata = '0;
    endcase
  end

  cvc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_tvalid(s_axis_tvalid), .in_tready(s_axis_tready),
    .out_busy(m_axis_tvalid && !m_axis_tready), .stat(stat), .cmd(cmd)
  );

  cvc_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .func(s_axis_tdata[1:0]), .operand_a(s_axis_tdata[33:2]),
    .operand_b(s_axis_tdata[65:34]),
    .vw(vw), .vh(vh), .cx(cx), .cy(cy), .aw(aw), .ah(ah),
    .res_x(res_x), .res_y(res_y), .res_hw(res_hw), .res_hh(res_hh),
    .res_zoom(res_zoom)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load)
      m_axis_tdata <= {3'd0, res_zoom, res_hh, res_hw, res_y, res_x};
  end

endmodule

// File: rtl/core/cvc_checker.sv
`include "camera_view_clamp_assert.svh"

module cvc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata,
  input logic         pready
);

  `CVC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CVC_ASSERT_IMPL(a_zoom_floor, m_axis_tvalid, m_axis_tdata[156:126] >= 31'd66)
  `CVC_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CVC_ASSERT_IMPL(a_pready, 1'b1, pready)

endmodule

bind camera_view_clamp cvc_checker u_cvc_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .pready(pready)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [30:0] zoom;
    logic [30:0] hh;
    logic [30:0] hw;
    logic [31:0] py;
    logic [31:0] px;
  } view_t;

  typedef struct {
    logic [1:0]  fn;
    logic [31:0] a;
    logic [31:0] b;
    logic        chk;
    view_t       want;
  } cmd_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [159:0] m_axis_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  camera_view_clamp u_top (.*);

  always #5 clk = ~clk;

  longint vw, vh, cx, cy, aw, ah, cam_x, cam_y, zl;
  view_t views_due[$];
  int errors = 0;
  int cycles = 0;
  int out_wait = 0;
  bit stim_done = 0;

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint view_ratio(longint vp, longint ar);
    longint unsigned q;
    if (ar == 0) return 2147483647;
    q = (longint'(vp) << 32) / ar;
    return (q > 2147483647) ? 2147483647 : q;
  endfunction

  function automatic longint clamp_to_area(longint p, longint c, longint sz, longint h);
    longint ha, lo, hi, x, y;
    ha = sz >>> 1;
    x = c - ha + h;
    y = c + ha - h;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    if (p < lo) p = lo;
    if (p > hi) p = hi;
    return sat_q(p);
  endfunction

  function automatic view_t predict_view(logic [1:0] fn, logic [31:0] ra, logic [31:0] rb);
    longint a, b, r, fz, hw, hh;
    view_t v;
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    case (fn)
      cvc_pkg::FN_SET_POS: begin cam_x = a; cam_y = b; end
      cvc_pkg::FN_MOVE: begin cam_x = sat_q(cam_x + a); cam_y = sat_q(cam_y + b); end
      cvc_pkg::FN_SET_ZOOM: zl = a;
      default: zl = sat_q(zl + a);
    endcase
    if (zl < 66) zl = 66;
    r = view_ratio(vw, aw);
    if (view_ratio(vh, ah) < r) r = view_ratio(vh, ah);
    fz = r + zl;
    if (fz > 2147483647) fz = 2147483647;
    if (fz < 66191) fz = 66191;
    hw = (vw << 31) / fz;
    hh = (vh << 31) / fz;
    cam_x = clamp_to_area(cam_x, cx, aw, hw);
    cam_y = clamp_to_area(cam_y, cy, ah, hh);
    v.px = cam_x[31:0];
    v.py = cam_y[31:0];
    v.hw = hw[30:0];
    v.hh = hh[30:0];
    v.zoom = zl[30:0];
    return v;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    case (idx)
      cvc_pkg::REG_VW: vw = longint'(val[13:0]);
      cvc_pkg::REG_VH: vh = longint'(val[13:0]);
      cvc_pkg::REG_CX: cx = longint'($signed(val));
      cvc_pkg::REG_CY: cy = longint'($signed(val));
      cvc_pkg::REG_AW: aw = longint'(val[30:0]);
      default: ah = longint'(val[30:0]);
    endcase
  endtask

  task automatic send_cmd(logic [1:0] fn, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'b0, b, a, fn};
    do @(posedge clk); while (!s_axis_tready);
    views_due.push_back(predict_view(fn, a, b));
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (views_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 2000) - 1000;
      3: return ($urandom_range(0, 4000) - 2000) << 16;
      default: return $urandom;
    endcase
  endfunction

  // result side: random ready back-pressure per transaction, compare against the oldest prediction
  always @(posedge clk) begin
    view_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = view_t'(m_axis_tdata[156:0]);
        if (views_due.size() == 0) begin
          report("unexpected transaction", got.px, 32'd0);
        end else begin
          want = views_due.pop_front();
          if (got.px !== want.px) report("pos_x", got.px, want.px);
          if (got.py !== want.py) report("pos_y", got.py, want.py);
          if (got.hw !== want.hw) report("half_width", {1'b0, got.hw}, {1'b0, want.hw});
          if (got.hh !== want.hh) report("half_height", {1'b0, got.hh}, {1'b0, want.hh});
          if (got.zoom !== want.zoom)
            report("zoom_out", {1'b0, got.zoom}, {1'b0, want.zoom});
        end
        out_wait = $urandom_range(0, 5);
        m_axis_tready <= (out_wait == 0);
      end else if (!m_axis_tready) begin
        if (out_wait != 0) out_wait--;
        m_axis_tready <= (out_wait == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  cmd_row_t rows[$];

  initial begin
    cmd_row_t row;
    view_t got;
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
    vw = 1024; vh = 768; cx = 0; cy = 0; aw = 67108864; ah = 50331648;
    cam_x = 0; cam_y = 0; zl = 66;

    // directed: set, move, zoom extremes, saturation
    rows = '{
      '{cvc_pkg::FN_SET_POS, 32'h0, 32'h0, 1'b1,
        '{31'd66, 31'd24916792, 31'd33222390, 32'h0, 32'h0}},
      '{cvc_pkg::FN_SET_POS, 32'h7fffffff, 32'h80000000, 1'b0, '0},
      '{cvc_pkg::FN_SET_POS, 32'h80000000, 32'h7fffffff, 1'b0, '0},
      '{cvc_pkg::FN_MOVE, 32'h7fffffff, 32'h7fffffff, 1'b0, '0},
      '{cvc_pkg::FN_MOVE, 32'h80000000, 32'h80000000, 1'b0, '0},
      '{cvc_pkg::FN_SET_ZOOM, 32'h0, 32'h0, 1'b0, '0},
      '{cvc_pkg::FN_SET_ZOOM, 32'h80000000, 32'hffffffff, 1'b0, '0},
      '{cvc_pkg::FN_SET_ZOOM, 32'h7fffffff, 32'h0, 1'b0, '0},
      '{cvc_pkg::FN_ADD_ZOOM, 32'h7fffffff, 32'h0, 1'b0, '0},
      '{cvc_pkg::FN_ADD_ZOOM, 32'h80000000, 32'h0, 1'b0, '0},
      '{cvc_pkg::FN_SET_ZOOM, 32'h00010000, 32'h0, 1'b0, '0},
      '{cvc_pkg::FN_MOVE, 32'h01000000, 32'hff000000, 1'b0, '0},
      '{cvc_pkg::FN_ADD_ZOOM, 32'hfffff000, 32'h12345678, 1'b0, '0}
    };
    foreach (rows[i]) begin
      row = rows[i];
      send_cmd(row.fn, row.a, row.b);
      if (row.chk && views_due[$] !== row.want) begin
        got = views_due[$];
        report("table row", {1'b0, got.hw}, {1'b0, row.want.hw});
      end
    end
    drain();

    // odd, tiny and zero-height viewports / areas
    write_reg(cvc_pkg::REG_VW, 32'h0000ffff);
    write_reg(cvc_pkg::REG_VH, 32'd0);
    write_reg(cvc_pkg::REG_AW, 32'h00010001);
    write_reg(cvc_pkg::REG_AH, 32'hffffffff);
    write_reg(cvc_pkg::REG_CX, 32'h7fffffff);
    write_reg(cvc_pkg::REG_CY, 32'h80000000);
    for (int i = 0; i < 8; i++) send_cmd(2'(i), rand_q(), rand_q());
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(cvc_pkg::REG_VW,
                (ph == 1) ? 32'd8192 : (ph == 2) ? 32'd1 : $urandom_range(1, 8192));
      write_reg(cvc_pkg::REG_VH, (ph == 1) ? 32'd8192 : (ph == 2) ? 32'd1 : $urandom);
      write_reg(cvc_pkg::REG_CX, rand_q());
      write_reg(cvc_pkg::REG_CY, rand_q());
      write_reg(cvc_pkg::REG_AW,
                (ph == 1) ? 32'd65536 : (ph == 2) ? 32'h7fffffff : $urandom);
      write_reg(cvc_pkg::REG_AH,
                (ph == 3) ? 32'd0 : $urandom_range(65536, 32'h7fffffff));
      for (int i = 0; i < 250; i++)
        send_cmd(2'($urandom_range(0, 3)), rand_q(), rand_q());
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: camera_view_clamp.f
+incdir+rtl/core
rtl/core/cvc_pkg.sv
rtl/core/cvc_div.sv
rtl/core/cvc_ctrl.sv
rtl/core/cvc_dp.sv
rtl/core/camera_view_clamp.sv
rtl/core/cvc_checker.sv
bench/tb_top.sv
